>>> hw/rtl/rbst_pkg.sv
// Package: types, constants and helpers for the ray box slab test.
package rbst_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] box_min_x;
    logic signed [CoordWidth-1:0] box_min_y;
    logic signed [CoordWidth-1:0] box_min_z;
    logic signed [CoordWidth-1:0] box_max_x;
    logic signed [CoordWidth-1:0] box_max_y;
    logic signed [CoordWidth-1:0] box_max_z;
  } box_word_t;

  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] t_entry;
    logic signed [CoordWidth-1:0] t_exit;
  } slab_word_t;

endpackage

>>> hw/rtl/rbst_div.sv
// Pipelined signed saturating fixed-point divider, one quotient bit per stage.
module rbst_div #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW:0]   num_i,
  input  logic signed [CW-1:0] den_i,
  output logic signed [CW-1:0] quo_o
);
  import rbst_pkg::*;

  // numerator magnitude (CW+1 bits) shifted left by FB; quotient needs NW bits
  localparam int unsigned NW = CW + 1 + FB;
  localparam int unsigned DW = CW;
  localparam int unsigned NS = NW;

  logic [NW-1:0] n_q   [NS+1];
  logic [NW-1:0] q_q   [NS+1];
  logic [DW:0]   r_q   [NS+1];
  logic [DW-1:0] d_q   [NS+1];
  logic          neg_q [NS+1];
  logic          dz_q  [NS+1];
  logic          nz_q  [NS+1];
  logic          nneg_q[NS+1];

  logic [CW:0]   nmag;
  logic [CW-1:0] dmag;

  always_comb begin
    nmag = num_i[CW] ? (CW+1)'(-num_i) : num_i;
    dmag = den_i[CW-1] ? CW'(-den_i) : den_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= {nmag, FB'(0)};
      q_q[0]    <= '0;
      r_q[0]    <= '0;
      d_q[0]    <= dmag;
      neg_q[0]  <= num_i[CW] ^ den_i[CW-1];
      dz_q[0]   <= (den_i == '0);
      nz_q[0]   <= (num_i == '0);
      nneg_q[0] <= num_i[CW];
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW+1:0] rs;
    logic [DW+1:0] df;
    always_comb begin
      rs = {r_q[s], n_q[s][NW-1-s]};
      df = rs - {2'b00, d_q[s]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1]    <= n_q[s];
        q_q[s+1]    <= {q_q[s][NW-2:0], ~df[DW+1]};
        r_q[s+1]    <= df[DW+1] ? rs[DW:0] : df[DW:0];
        d_q[s+1]    <= d_q[s];
        neg_q[s+1]  <= neg_q[s];
        dz_q[s+1]   <= dz_q[s];
        nz_q[s+1]   <= nz_q[s];
        nneg_q[s+1] <= nneg_q[s];
      end
    end
  end

  logic [NW-1:0] lim;
  logic [NW-1:0] mag;
  always_comb begin
    lim = neg_q[NS] ? (NW'(1) << (CW-1)) : ((NW'(1) << (CW-1)) - NW'(1));
    mag = (q_q[NS] > lim) ? lim : q_q[NS];
    if (nz_q[NS]) begin
      quo_o = '0;
    end else if (dz_q[NS]) begin
      quo_o = nneg_q[NS] ? {1'b1, (CW-1)'(0)} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      quo_o = neg_q[NS] ? CW'(-mag) : CW'(mag);
    end
  end

endmodule

>>> hw/rtl/rbst_axis.sv
// One axis: differences, two dividers, ordered entry and exit distances.
module rbst_axis #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] lo_i,
  input  logic signed [CW-1:0] hi_i,
  input  logic signed [CW-1:0] org_i,
  input  logic signed [CW-1:0] dir_i,
  output logic signed [CW-1:0] t_lo_o,
  output logic signed [CW-1:0] t_hi_o
);
  import rbst_pkg::*;

  logic signed [CW:0]   d1_q, d2_q;
  logic signed [CW-1:0] dir_q;
  logic signed [CW-1:0] t1, t2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q  <= (CW+1)'(lo_i) - (CW+1)'(org_i);
      d2_q  <= (CW+1)'(hi_i) - (CW+1)'(org_i);
      dir_q <= dir_i;
    end
  end

  rbst_div #(.CW(CW), .FB(FB)) u_div1 (
    .clk_i, .en_i, .num_i(d1_q), .den_i(dir_q), .quo_o(t1)
  );
  rbst_div #(.CW(CW), .FB(FB)) u_div2 (
    .clk_i, .en_i, .num_i(d2_q), .den_i(dir_q), .quo_o(t2)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_lo_o <= (t1 < t2) ? t1 : t2;
      t_hi_o <= (t1 < t2) ? t2 : t1;
    end
  end

endmodule

>>> hw/rtl/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test pipeline.
// Usage:
//   Write the ray origin and direction through cfg_we_i/cfg_idx_i/cfg_data_i
//   while the pipeline is empty (index 0..2 origin x,y,z; 3..5 direction).
//   Boxes enter on box_valid_i/box_i; a word is taken when valid is high
//   and box_stall_o is low. Results leave on res_valid_o/res_o and are
//   taken when res_stall_i is low.
//   Stages: one subtract stage, one setup stage, CoordWidth+FRAC_BITS+1
//   restoring quotient-bit stages, an ordering stage and two min/max
//   compare stages.
//   Throughput: one box per cycle. The whole pipe advances unless the
//   output word is held and stalled; then box_stall_o is raised and no
//   data moves.
//   Reset clears valid bits and loads origin 0, direction (1.0, 0, 0).
module ray_box_slab_test #(
  parameter int unsigned FRAC_BITS   = rbst_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rbst_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rbst_pkg::CoordWidth-1:0] cfg_data_i,
  input  logic                         box_valid_i,
  output logic                         box_stall_o,
  input  rbst_pkg::box_word_t          box_i,
  output logic                         res_valid_o,
  input  logic                         res_stall_i,
  output rbst_pkg::slab_word_t         res_o
);
  import rbst_pkg::*;

  localparam int unsigned CW  = CoordWidth;
  localparam int unsigned LAT = CW + FRAC_BITS + 1 + 1 + 1 + 1 + 1 + 1;

  logic signed [CW-1:0] org_q [3];
  logic signed [CW-1:0] dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= CW'(1) << FRAC_BITS;
      dir_q[1] <= '0;
      dir_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORG_X: org_q[0] <= cfg_data_i;
        REG_ORG_Y: org_q[1] <= cfg_data_i;
        REG_ORG_Z: org_q[2] <= cfg_data_i;
        REG_DIR_X: dir_q[0] <= cfg_data_i;
        REG_DIR_Y: dir_q[1] <= cfg_data_i;
        REG_DIR_Z: dir_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld_q;
  assign en          = !(vld_q[LAT-1] && res_stall_i);
  assign box_stall_o = !en;
  assign res_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], box_valid_i};
    end
  end

  logic signed [CW-1:0] bmin [3];
  logic signed [CW-1:0] bmax [3];
  logic signed [CW-1:0] tl   [3];
  logic signed [CW-1:0] th   [3];

  assign bmin[0] = CW'(box_i.box_min_x);
  assign bmin[1] = CW'(box_i.box_min_y);
  assign bmin[2] = CW'(box_i.box_min_z);
  assign bmax[0] = CW'(box_i.box_max_x);
  assign bmax[1] = CW'(box_i.box_max_y);
  assign bmax[2] = CW'(box_i.box_max_z);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbst_axis #(.CW(CW), .FB(FRAC_BITS)) u_axis (
      .clk_i, .en_i(en), .lo_i(bmin[a]), .hi_i(bmax[a]),
      .org_i(org_q[a]), .dir_i(dir_q[a]), .t_lo_o(tl[a]), .t_hi_o(th[a])
    );
  end

  logic signed [CW-1:0] e01_q, x01_q, e2_q, x2_q, ent_q, ext_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e01_q <= (tl[1] > tl[0]) ? tl[1] : tl[0];
      x01_q <= (th[1] < th[0]) ? th[1] : th[0];
      e2_q  <= tl[2];
      x2_q  <= th[2];
      ent_q <= (e2_q > e01_q) ? e2_q : e01_q;
      ext_q <= (x2_q < x01_q) ? x2_q : x01_q;
    end
  end

  always_comb begin
    res_o.hit     = ext_q > ent_q;
    res_o.t_entry = ent_q;
    res_o.t_exit  = ext_q;
  end

endmodule

>>> verif/tb_top.sv
// Testbench for the ray versus axis-aligned box slab test pipeline.
`timescale 1ns / 1ps

module tb_top;
  import rbst_pkg::*;

  localparam int unsigned Latency   = CoordWidth + FracBits + 6;
  localparam int unsigned MaxCycles = 600000;
  localparam int unsigned ItemsPerPhase = 60;
  localparam int unsigned NumPhases = 9;

  class slab_scoreboard;
    logic signed [CoordWidth-1:0] origin [3];
    logic signed [CoordWidth-1:0] dir [3];
    slab_word_t expected_q [$];
    int unsigned errors;

    function new();
      errors = 0;
      origin = '{0, 0, 0};
      dir = '{32'sd65536, 0, 0};
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CoordWidth-1:0] val);
      case (idx)
        REG_ORG_X: origin[0] = val;
        REG_ORG_Y: origin[1] = val;
        REG_ORG_Z: origin[2] = val;
        REG_DIR_X: dir[0] = val;
        REG_DIR_Y: dir[1] = val;
        REG_DIR_Z: dir[2] = val;
        default: ;
      endcase
    endfunction

    // Saturated (bound - origin) * 2^FracBits / dir, truncated toward zero.
    function longint slab_dist(logic signed [CoordWidth-1:0] bound,
                               logic signed [CoordWidth-1:0] org,
                               logic signed [CoordWidth-1:0] d);
      longint diff, dv, nmag, dmag, m, lim;
      bit neg;
      diff = longint'(bound) - longint'(org);
      dv = longint'(d);
      nmag = (diff < 0) ? -diff : diff;
      dmag = (dv < 0) ? -dv : dv;
      if (dmag == 0) begin
        if (nmag == 0) return 0;
        return (diff < 0) ? -(longint'(1) << (CoordWidth - 1))
                          : (longint'(1) << (CoordWidth - 1)) - 1;
      end
      if (nmag == 0) return 0;
      neg = (diff < 0) != (dv < 0);
      lim = neg ? (longint'(1) << (CoordWidth - 1)) : (longint'(1) << (CoordWidth - 1)) - 1;
      m = (nmag << FracBits) / dmag;
      if (m > lim) m = lim;
      return neg ? -m : m;
    endfunction

    function void note_box(box_word_t b);
      logic signed [CoordWidth-1:0] lo_b [3];
      logic signed [CoordWidth-1:0] hi_b [3];
      longint t1, t2, lo, hi, entry, exitv;
      slab_word_t w;
      lo_b = '{b.box_min_x, b.box_min_y, b.box_min_z};
      hi_b = '{b.box_max_x, b.box_max_y, b.box_max_z};
      entry = 0;
      exitv = 0;
      for (int a = 0; a < 3; a++) begin
        t1 = slab_dist(lo_b[a], origin[a], dir[a]);
        t2 = slab_dist(hi_b[a], origin[a], dir[a]);
        lo = (t1 < t2) ? t1 : t2;
        hi = (t1 < t2) ? t2 : t1;
        if (a == 0 || lo > entry) entry = lo;
        if (a == 0 || hi < exitv) exitv = hi;
      end
      w.hit = exitv > entry;
      w.t_entry = entry[CoordWidth-1:0];
      w.t_exit = exitv[CoordWidth-1:0];
      expected_q.insert(expected_q.size(), w);
    endfunction

    function void check_res(slab_word_t r);
      slab_word_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", r);
        return;
      end
      e = expected_q.pop_front();
      if (r.hit !== e.hit || r.t_entry !== e.t_entry || r.t_exit !== e.t_exit) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp hit=%b entry=%h exit=%h, got hit=%b entry=%h exit=%h",
                   e.hit, e.t_entry, e.t_exit, r.hit, r.t_entry, r.t_exit);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CoordWidth-1:0] cfg_data_i;
  logic box_valid_i;
  logic box_stall_o;
  box_word_t box_i;
  logic res_valid_o;
  logic res_stall_i;
  slab_word_t res_o;

  slab_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt = 0;
  bit quiet = 1'b0;

  ray_box_slab_test u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .box_valid_i, .box_stall_o, .box_i, .res_valid_o, .res_stall_i, .res_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && box_valid_i && !box_stall_o) sb.note_box(box_i);
    if (rst_ni && res_valid_o && !res_stall_i) sb.check_res(res_o);
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall process
  initial begin
    int unsigned stall_cnt;
    stall_cnt = 0;
    res_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        res_stall_i <= 1'b1;
        hold_cnt--;
      end else if (stall_cnt > 0) begin
        res_stall_i <= 1'b1;
        stall_cnt--;
      end else begin
        res_stall_i <= 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) stall_cnt = gap_len();
      end
    end
  end

  function automatic logic [CoordWidth-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [CoordWidth-1:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'h0000_0001;
      4: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CoordWidth-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_box(box_word_t b);
    int unsigned g;
    box_valid_i <= 1'b1;
    box_i <= b;
    do @(posedge clk_i); while (box_stall_o);
    g = 0;
    if (!quiet && $urandom_range(0, 2) == 0) g = gap_len();
    if (g > 0) begin
      box_valid_i <= 1'b0;
      box_i <= box_word_t'({6{$urandom()}});
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    box_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic box_word_t rand_box(bit near);
    box_word_t b;
    logic [CoordWidth-1:0] c;
    if (near) begin
      c = sb.origin[0] + $urandom_range(0, 32'h0008_0000);
      b.box_min_x = c; b.box_max_x = c + $urandom_range(0, 32'h0004_0000);
      c = sb.origin[1] - $urandom_range(0, 32'h0002_0000);
      b.box_min_y = c; b.box_max_y = c + $urandom_range(0, 32'h0004_0000);
      c = sb.origin[2] - $urandom_range(0, 32'h0002_0000);
      b.box_min_z = c; b.box_max_z = c + $urandom_range(0, 32'h0004_0000);
      if ($urandom_range(0, 7) == 0) b.box_min_x = b.box_max_x + 1;
    end else begin
      b.box_min_x = rand_coord(); b.box_min_y = rand_coord(); b.box_min_z = rand_coord();
      b.box_max_x = rand_coord(); b.box_max_y = rand_coord(); b.box_max_z = rand_coord();
    end
    return b;
  endfunction

  initial begin
    box_word_t b;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_ORG_X;
    cfg_data_i <= '0;
    box_valid_i <= 1'b0;
    box_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words on the reset ray
    send_box('{32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000,
               32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000});
    send_box('{-32'sh0003_0000, -32'sh0001_0000, -32'sh0001_0000,
               -32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000});
    send_box('{32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 0});
    send_box('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
    send_box('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    send_box('{0, 0, 0, 0, 0, 0});
    send_box('{32'shffff_ffff, 32'shffff_ffff, 1, 1, 1, 32'shffff_ffff});
    send_box('{32'sh0001_0000, 32'sh0002_0000, -32'sh0002_0000,
               32'sh0003_0000, 32'sh0003_0000, -32'sh0001_0000});
    drain();

    // extreme ray: origin x and y at the limits, z zero, direction tiny and huge
    write_reg(REG_ORG_X, 32'h8000_0000);
    write_reg(REG_ORG_Y, 32'h7fff_ffff);
    write_reg(REG_ORG_Z, '0);
    write_reg(REG_DIR_X, 32'h0000_0001);
    write_reg(REG_DIR_Y, 32'h8000_0000);
    write_reg(REG_DIR_Z, 32'h7fff_ffff);
    send_box('{32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7fff_ffff, 1});
    send_box('{0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh7fff_ffff});
    send_box('{32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh8000_0001, 32'sh7fff_fffe, 0});
    send_box('{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      write_reg(REG_ORG_X, rand_coord());
      write_reg(REG_ORG_Y, rand_coord());
      write_reg(REG_ORG_Z, rand_coord());
      write_reg(REG_DIR_X, rand_dir());
      write_reg(REG_DIR_Y, rand_dir());
      write_reg(REG_DIR_Z, rand_dir());
      quiet = (ph == 1);
      if (ph == 3) hold_cnt = 300;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        b = rand_box($urandom_range(0, 3) != 0);
        send_box(b);
      end
    end
    quiet = 1'b0;

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
